[rtl/mccl_pkg.sv]
// mccl_pkg: shared types and constants for the midi controller pitch block
// no dependencies; used by mccl_step, the top level and the checker
package mccl_pkg;

  // event commands
  localparam logic [1:0] CMD_CTRL  = 2'd0;
  localparam logic [1:0] CMD_NOTE  = 2'd1;
  localparam logic [1:0] CMD_LEARN = 2'd2;

  // learn roles
  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_DOWN  = 2'd1;
  localparam logic [1:0] ROLE_UP    = 2'd2;
  localparam logic [1:0] ROLE_RESET = 2'd3;

  // reported actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_DOWN  = 3'd1;
  localparam logic [2:0] ACT_UP    = 3'd2;
  localparam logic [2:0] ACT_RESET = 3'd3;
  localparam logic [2:0] ACT_LEARN = 3'd4;

  localparam logic [6:0] PRESS_LEVEL = 7'd64;
  localparam logic [6:0] NOTE_DOWN   = 7'd60;
  localparam logic [6:0] NOTE_UP     = 7'd62;
  localparam logic [6:0] NOTE_RESET  = 7'd64;

  localparam logic signed [4:0] PITCH_MIN  = -5'sd12;
  localparam logic signed [4:0] PITCH_MAX  = 5'sd12;
  localparam logic signed [4:0] PITCH_ZERO = 5'sd0;

  localparam logic [6:0] DOWN_CTRL_RST  = 7'd30;
  localparam logic [6:0] UP_CTRL_RST    = 7'd31;
  localparam logic [6:0] RESET_CTRL_RST = 7'd32;

  // one event held in the input register
  typedef struct packed {
    logic [1:0] command;
    logic [6:0] number;
    logic       press;     // controller value at or above press level
    logic [1:0] role;
    logic       in_range;  // controller number below controller count
    logic       was;       // stored pressed bit for this controller
  } mccl_item_t;

  typedef struct packed {
    logic [1:0]        armed;
    logic [6:0]        down_ctrl;
    logic [6:0]        up_ctrl;
    logic [6:0]        reset_ctrl;
    logic signed [4:0] pitch;
  } mccl_state_t;

  typedef struct packed {
    mccl_state_t state;
    logic [2:0]  act;
    logic        press_we;
    logic        press_val;
  } mccl_step_t;

endpackage

[rtl/mccl_step.sv]
// mccl_step: next-state and action logic for one event
// depends on mccl_pkg
module mccl_step (
  input  mccl_pkg::mccl_item_t  item,
  input  mccl_pkg::mccl_state_t cur,
  output mccl_pkg::mccl_step_t  res
);

  mccl_pkg::mccl_state_t nxt;
  logic [2:0]            act;

  always_comb begin
    nxt = cur;
    act = mccl_pkg::ACT_NONE;
    unique case (item.command)
      mccl_pkg::CMD_CTRL: begin
        if (item.in_range) begin
          if (cur.armed != mccl_pkg::ROLE_NONE) begin
            case (cur.armed)
              mccl_pkg::ROLE_DOWN: nxt.down_ctrl = item.number;
              mccl_pkg::ROLE_UP:   nxt.up_ctrl = item.number;
              default:             nxt.reset_ctrl = item.number;
            endcase
            nxt.armed = mccl_pkg::ROLE_NONE;
            act = mccl_pkg::ACT_LEARN;
          end else if (item.press && !item.was) begin
            // down wins over up, up over reset
            if (item.number == cur.down_ctrl) begin
              act = mccl_pkg::ACT_DOWN;
            end else if (item.number == cur.up_ctrl) begin
              act = mccl_pkg::ACT_UP;
            end else if (item.number == cur.reset_ctrl) begin
              act = mccl_pkg::ACT_RESET;
            end
          end
        end
      end
      mccl_pkg::CMD_NOTE: begin
        if (item.number == mccl_pkg::NOTE_DOWN) begin
          act = mccl_pkg::ACT_DOWN;
        end else if (item.number == mccl_pkg::NOTE_UP) begin
          act = mccl_pkg::ACT_UP;
        end else if (item.number == mccl_pkg::NOTE_RESET) begin
          act = mccl_pkg::ACT_RESET;
        end
      end
      mccl_pkg::CMD_LEARN: begin
        nxt.armed = item.role;
      end
      default: begin
      end
    endcase

    // saturating pitch step
    case (act)
      mccl_pkg::ACT_DOWN: begin
        if (cur.pitch > mccl_pkg::PITCH_MIN) nxt.pitch = cur.pitch - 5'sd1;
      end
      mccl_pkg::ACT_UP: begin
        if (cur.pitch < mccl_pkg::PITCH_MAX) nxt.pitch = cur.pitch + 5'sd1;
      end
      mccl_pkg::ACT_RESET: nxt.pitch = mccl_pkg::PITCH_ZERO;
      default: begin
      end
    endcase
  end

  assign res.state     = nxt;
  assign res.act       = act;
  assign res.press_we  = (item.command == mccl_pkg::CMD_CTRL) && item.in_range;
  assign res.press_val = item.press;

endmodule

[rtl/midi_cc_pitch_control_with_learn.sv]
// midi_cc_pitch_control_with_learn: top level, pitch offset from midi events with cc learn
// depends on mccl_pkg and mccl_step
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   event   | evt_valid / evt_stall  | command, number, ctrl_value, learn_role
//   result  | res_valid / res_stall  | pitch_semitones, action, learning, *_assign
//
// one result per event; each event passes through the input register and then the result register
// a new event is taken every cycle while evt_stall is low; the state update happens in one pass of
// mccl_step between the input register and the result register
// the pressed bit of a controller is read when the event is taken and
// forwarded from the event being retired in that same cycle
// rst is synchronous: pressed bits cleared, assignments 30/31/32, pitch 0
// a stall on the result side holds the result and the queued event; the
// event side stalls only when both registers are full
module midi_cc_pitch_control_with_learn #(
  parameter int CTRL_COUNT = 128
) (
  input  logic              clk,
  input  logic              rst,
  // event channel
  input  logic              evt_valid,
  output logic              evt_stall,
  input  logic [1:0]        command,
  input  logic [6:0]        number,
  input  logic [6:0]        ctrl_value,
  input  logic [1:0]        learn_role,
  // result channel
  output logic              res_valid,
  input  logic              res_stall,
  output logic signed [4:0] pitch_semitones,
  output logic [2:0]        action,
  output logic              learning,
  output logic [6:0]        down_assign,
  output logic [6:0]        up_assign,
  output logic [6:0]        reset_assign
);

  localparam int IDX_W = (CTRL_COUNT > 1) ? $clog2(CTRL_COUNT) : 1;

  // input register
  logic                  item_valid;
  mccl_pkg::mccl_item_t  item;
  mccl_pkg::mccl_item_t  item_next;

  // block state
  logic [CTRL_COUNT-1:0] pressed;
  mccl_pkg::mccl_state_t st;
  mccl_pkg::mccl_step_t  step;

  logic                  advance;    // queued event retires into the result register
  logic                  evt_xfer;
  logic                  fwd;
  logic                  in_range;

  assign advance   = item_valid && !(res_valid && res_stall);
  assign evt_stall = item_valid && !advance;
  assign evt_xfer  = evt_valid && !evt_stall;

  assign in_range = {1'b0, number} < 8'(CTRL_COUNT);

  // bypass the pressed bit being written by the retiring event
  assign fwd = advance && step.press_we && (item.number == number);

  always_comb begin
    item_next.command  = command;
    item_next.number   = number;
    item_next.press    = ctrl_value >= mccl_pkg::PRESS_LEVEL;
    item_next.role     = learn_role;
    item_next.in_range = in_range;
    if (!in_range) begin
      item_next.was = 1'b0;
    end else if (fwd) begin
      item_next.was = step.press_val;
    end else begin
      item_next.was = pressed[number[IDX_W-1:0]];
    end
  end

  mccl_step u_step (
    .item (item),
    .cur  (st),
    .res  (step)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (evt_xfer) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (evt_xfer) begin
      item <= item_next;
    end
  end

  // state registers and pressed bits
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed       <= '0;
      st.armed      <= mccl_pkg::ROLE_NONE;
      st.down_ctrl  <= mccl_pkg::DOWN_CTRL_RST;
      st.up_ctrl    <= mccl_pkg::UP_CTRL_RST;
      st.reset_ctrl <= mccl_pkg::RESET_CTRL_RST;
      st.pitch      <= mccl_pkg::PITCH_ZERO;
    end else if (advance) begin
      st <= step.state;
      if (step.press_we) begin
        pressed[item.number[IDX_W-1:0]] <= step.press_val;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      pitch_semitones <= step.state.pitch;
      action          <= step.act;
      learning        <= step.state.armed != mccl_pkg::ROLE_NONE;
      down_assign     <= step.state.down_ctrl;
      up_assign       <= step.state.up_ctrl;
      reset_assign    <= step.state.reset_ctrl;
    end
  end

endmodule

[rtl/mccl_checker.sv]
// mccl_checker: port-level assertions for the midi controller pitch block
// depends on mccl_pkg; bound to midi_cc_pitch_control_with_learn
module mccl_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_stall,
  input logic signed [4:0] pitch_semitones,
  input logic [2:0]        action,
  input logic              learning
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pitch_semitones >= mccl_pkg::PITCH_MIN) &&
                  (pitch_semitones <= mccl_pkg::PITCH_MAX))
    else $error("pitch out of range");

  // a learned assignment always disarms
  a_learn_disarms: assert property (@(posedge clk) disable iff (rst)
    res_valid && (action == mccl_pkg::ACT_LEARN) |-> !learning)
    else $error("still learning after assignment");

  a_reset_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (action == mccl_pkg::ACT_RESET) |-> pitch_semitones == mccl_pkg::PITCH_ZERO)
    else $error("pitch not zero after reset action");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(pitch_semitones) && $stable(action))
    else $error("stalled result changed");

endmodule

bind midi_cc_pitch_control_with_learn mccl_checker u_mccl_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res_valid),
  .res_stall       (res_stall),
  .pitch_semitones (pitch_semitones),
  .action          (action),
  .learning        (learning)
);
